>>> src/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types, constants and fixed-point helpers for the radial-tangential
// point distortion block.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

  localparam int unsigned QW          = 32;
  localparam int unsigned QFRAC       = 24;
  localparam int unsigned NUM_W       = QW + QFRAC;
  localparam int unsigned DIV_STEPS   = 4;
  localparam int unsigned DIV_STAGES  = NUM_W / DIV_STEPS;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K1 = 3'd0,
    REG_K2 = 3'd1,
    REG_K3 = 3'd2,
    REG_P1 = 3'd3,
    REG_P2 = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [QW-1:0] k1;
    logic signed [QW-1:0] k2;
    logic signed [QW-1:0] k3;
    logic signed [QW-1:0] p1;
    logic signed [QW-1:0] p2;
  } coef_t;

  typedef struct packed {
    logic                 clip;
    logic signed [QW-1:0] val;
  } sat_t;

  // One divider stage word: two lanes sharing the divisor.
  typedef struct packed {
    logic             bad;
    logic             neg_x;
    logic             neg_y;
    logic [QW-2:0]    dvs;
    logic [QW-1:0]    rem_x;
    logic [NUM_W-1:0] num_x;
    logic [QW-1:0]    rem_y;
    logic [NUM_W-1:0] num_y;
  } div_word_t;

  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;
  localparam logic signed [63:0] Q_HALF  = 64'sd8388608;
  localparam logic signed [39:0] Q_ONE   = 40'sd16777216;

  function automatic logic signed [39:0] sx40(logic signed [QW-1:0] a);
    return $signed({{8{a[QW-1]}}, a});
  endfunction

  function automatic sat_t sat40(logic signed [39:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.clip = 1'b1;
      r.val  = SAT_MAX[QW-1:0];
    end else if (v < SAT_MIN) begin
      r.clip = 1'b1;
      r.val  = SAT_MIN[QW-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = v[QW-1:0];
    end
    return r;
  endfunction

  // Round a raw Q16.48 product to Q8.24, nearest with ties up, then clip.
  function automatic sat_t qrnd(logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + Q_HALF;
    return sat40($signed(t[63:QFRAC]));
  endfunction

endpackage

`default_nettype wire

>>> src/rtp_div_stage.sv
// ----------------------------------------------------------------------------
// rtp_div_stage
// Four restoring-division steps on one lane; quotient bits shift into num.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_div_stage
  import rtp_pkg::*;
(
  input  logic [QW-2:0]    dvs_i,
  input  logic [QW-1:0]    rem_i,
  input  logic [NUM_W-1:0] num_i,
  output logic [QW-1:0]    rem_o,
  output logic [NUM_W-1:0] num_o
);

  always_comb begin
    logic [QW-1:0]    r;
    logic [NUM_W-1:0] n;
    logic [QW:0]      sh;
    r = rem_i;
    n = num_i;
    sh = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      sh = {r, n[NUM_W-1]};
      n  = {n[NUM_W-2:0], 1'b0};
      if (sh >= {2'b00, dvs_i}) begin
        sh   = sh - {2'b00, dvs_i};
        n[0] = 1'b1;
      end
      r = sh[QW-1:0];
    end
    rem_o = r;
    num_o = n;
  end

endmodule

`default_nettype wire

>>> src/rtp_divider.sv
// ----------------------------------------------------------------------------
// rtp_divider
// Pipelined projection divider: |X|*2^24 / Z and |Y|*2^24 / Z, both lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_divider
  import rtp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic signed [QW-1:0] px_i,
  input  logic signed [QW-1:0] py_i,
  input  logic signed [QW-1:0] pz_i,
  output logic                 vld_o,
  output div_word_t            word_o
);

  div_word_t               stg_q [DIV_STAGES+1];
  logic [DIV_STAGES:0]     vld_q;
  div_word_t               prep_d;
  logic [QW-1:0]           mag_x;
  logic [QW-1:0]           mag_y;

  always_comb begin
    mag_x = px_i[QW-1] ? (~px_i + 1'b1) : px_i;
    mag_y = py_i[QW-1] ? (~py_i + 1'b1) : py_i;
    prep_d.bad   = (pz_i[QW-1] == 1'b1) || (pz_i == '0);
    prep_d.neg_x = px_i[QW-1];
    prep_d.neg_y = py_i[QW-1];
    prep_d.dvs   = pz_i[QW-2:0];
    prep_d.rem_x = '0;
    prep_d.num_x = {mag_x, {QFRAC{1'b0}}};
    prep_d.rem_y = '0;
    prep_d.num_y = {mag_y, {QFRAC{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q[0] <= prep_d;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [QW-1:0]    rx, ry;
    logic [NUM_W-1:0] nx, ny;

    rtp_div_stage u_lane_x (
      .dvs_i (stg_q[s].dvs),
      .rem_i (stg_q[s].rem_x),
      .num_i (stg_q[s].num_x),
      .rem_o (rx),
      .num_o (nx)
    );

    rtp_div_stage u_lane_y (
      .dvs_i (stg_q[s].dvs),
      .rem_i (stg_q[s].rem_y),
      .num_i (stg_q[s].num_y),
      .rem_o (ry),
      .num_o (ny)
    );

    always_ff @(posedge clk_i) begin
      stg_q[s+1].bad   <= stg_q[s].bad;
      stg_q[s+1].neg_x <= stg_q[s].neg_x;
      stg_q[s+1].neg_y <= stg_q[s].neg_y;
      stg_q[s+1].dvs   <= stg_q[s].dvs;
      stg_q[s+1].rem_x <= rx;
      stg_q[s+1].num_x <= nx;
      stg_q[s+1].rem_y <= ry;
      stg_q[s+1].num_y <= ny;
    end
  end

  assign vld_o  = vld_q[DIV_STAGES];
  assign word_o = stg_q[DIV_STAGES];

endmodule

`default_nettype wire

>>> src/rtp_poly.sv
// ----------------------------------------------------------------------------
// rtp_poly
// Distortion arithmetic pipeline: alternating multiply and round/sum ranks.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_poly
  import rtp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  coef_t                coef_i,
  input  logic                 vld_i,
  input  div_word_t            word_i,
  output logic                 vld_o,
  output logic signed [QW-1:0] ox_o,
  output logic signed [QW-1:0] oy_o,
  output logic                 bad_o,
  output logic                 clip_o
);

  localparam int unsigned NSTG = 11;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] bad_q;
  logic [NSTG-1:0] clip_q;

  // stage 0: signed, clipped quotients
  logic signed [QW-1:0] s0_x_q, s0_y_q;
  // stage 1: raw squares and the x*y product
  logic signed [63:0]   s1_xx_q, s1_yy_q, s1_xy_q;
  logic signed [QW-1:0] s1_x_q, s1_y_q;
  // stage 2
  logic signed [QW-1:0] s2_x2_q, s2_y2_q, s2_xy_q, s2_r2_q, s2_x_q, s2_y_q;
  // stage 3
  logic signed [63:0]   s3_r4_q, s3_k1_q;
  logic signed [QW-1:0] s3_tx_q, s3_ty_q, s3_r2_q, s3_xy_q, s3_x_q, s3_y_q;
  // stage 4
  logic signed [QW-1:0] s4_r4_q, s4_a1_q, s4_tx_q, s4_ty_q, s4_r2_q, s4_xy_q;
  logic signed [QW-1:0] s4_x_q, s4_y_q;
  // stage 5
  logic signed [63:0]   s5_r6_q, s5_k2_q;
  logic signed [QW-1:0] s5_a1_q, s5_tx_q, s5_ty_q, s5_xy_q, s5_x_q, s5_y_q;
  // stage 6
  logic signed [QW-1:0] s6_r6_q, s6_a1_q, s6_a2_q, s6_tx_q, s6_ty_q, s6_xy_q;
  logic signed [QW-1:0] s6_x_q, s6_y_q;
  // stage 7
  logic signed [63:0]   s7_k3_q;
  logic signed [QW-1:0] s7_a1_q, s7_a2_q, s7_tx_q, s7_ty_q, s7_xy_q;
  logic signed [QW-1:0] s7_x_q, s7_y_q;
  // stage 8
  logic signed [QW-1:0] s8_f_q, s8_tx_q, s8_ty_q, s8_xy_q, s8_x_q, s8_y_q;
  // stage 9
  logic signed [63:0]   s9_xf_q, s9_yf_q, s9_p1xy_q, s9_p2tx_q, s9_p1ty_q;
  logic signed [63:0]   s9_p2xy_q;
  // stage 10
  logic signed [QW-1:0] s10_ox_q, s10_oy_q;

  // Quotient to signed Q8.24 with clipping.
  sat_t                 qx_s, qy_s;
  logic [NUM_W-1:0]     qx, qy;

  always_comb begin
    qx = word_i.num_x;
    qy = word_i.num_y;
    if (word_i.neg_x) begin
      qx_s.clip = (qx > NUM_W'(64'h8000_0000));
      qx_s.val  = qx_s.clip ? SAT_MIN[QW-1:0] : (~qx[QW-1:0] + 1'b1);
    end else begin
      qx_s.clip = (qx > NUM_W'(64'h7FFF_FFFF));
      qx_s.val  = qx_s.clip ? SAT_MAX[QW-1:0] : qx[QW-1:0];
    end
    if (word_i.neg_y) begin
      qy_s.clip = (qy > NUM_W'(64'h8000_0000));
      qy_s.val  = qy_s.clip ? SAT_MIN[QW-1:0] : (~qy[QW-1:0] + 1'b1);
    end else begin
      qy_s.clip = (qy > NUM_W'(64'h7FFF_FFFF));
      qy_s.val  = qy_s.clip ? SAT_MAX[QW-1:0] : qy[QW-1:0];
    end
  end

  // Round/sum ranks.
  sat_t x2_s, y2_s, xy_s, r2_s;
  sat_t tx_s, ty_s;
  sat_t r4_s, a1_s;
  sat_t r6_s, a2_s;
  sat_t a3_s, f_s;
  sat_t xf_s, yf_s, p1xy_s, p2tx_s, p1ty_s, p2xy_s, ox_s, oy_s;

  always_comb begin
    x2_s   = qrnd(s1_xx_q);
    y2_s   = qrnd(s1_yy_q);
    xy_s   = qrnd(s1_xy_q);
    r2_s   = sat40(sx40(x2_s.val) + sx40(y2_s.val));
    tx_s   = sat40(sx40(s2_r2_q) + (sx40(s2_x2_q) <<< 1));
    ty_s   = sat40(sx40(s2_r2_q) + (sx40(s2_y2_q) <<< 1));
    r4_s   = qrnd(s3_r4_q);
    a1_s   = qrnd(s3_k1_q);
    r6_s   = qrnd(s5_r6_q);
    a2_s   = qrnd(s5_k2_q);
    a3_s   = qrnd(s7_k3_q);
    f_s    = sat40(Q_ONE + sx40(s7_a1_q) + sx40(s7_a2_q) + sx40(a3_s.val));
    xf_s   = qrnd(s9_xf_q);
    yf_s   = qrnd(s9_yf_q);
    p1xy_s = qrnd(s9_p1xy_q);
    p2tx_s = qrnd(s9_p2tx_q);
    p1ty_s = qrnd(s9_p1ty_q);
    p2xy_s = qrnd(s9_p2xy_q);
    ox_s   = sat40(sx40(xf_s.val) + (sx40(p1xy_s.val) <<< 1) + sx40(p2tx_s.val));
    oy_s   = sat40(sx40(yf_s.val) + sx40(p1ty_s.val) + (sx40(p2xy_s.val) <<< 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q <= {bad_q[NSTG-2:0], word_i.bad};
    clip_q[0]  <= qx_s.clip | qy_s.clip;
    clip_q[1]  <= clip_q[0];
    clip_q[2]  <= clip_q[1] | x2_s.clip | y2_s.clip | xy_s.clip | r2_s.clip;
    clip_q[3]  <= clip_q[2] | tx_s.clip | ty_s.clip;
    clip_q[4]  <= clip_q[3] | r4_s.clip | a1_s.clip;
    clip_q[5]  <= clip_q[4];
    clip_q[6]  <= clip_q[5] | r6_s.clip | a2_s.clip;
    clip_q[7]  <= clip_q[6];
    clip_q[8]  <= clip_q[7] | a3_s.clip | f_s.clip;
    clip_q[9]  <= clip_q[8];
    clip_q[10] <= clip_q[9] | xf_s.clip | yf_s.clip | p1xy_s.clip | p2tx_s.clip
                | p1ty_s.clip | p2xy_s.clip | ox_s.clip | oy_s.clip;

    s0_x_q <= qx_s.val;
    s0_y_q <= qy_s.val;

    s1_xx_q <= 64'(s0_x_q) * 64'(s0_x_q);
    s1_yy_q <= 64'(s0_y_q) * 64'(s0_y_q);
    s1_xy_q <= 64'(s0_x_q) * 64'(s0_y_q);
    s1_x_q  <= s0_x_q;
    s1_y_q  <= s0_y_q;

    s2_x2_q <= x2_s.val;
    s2_y2_q <= y2_s.val;
    s2_xy_q <= xy_s.val;
    s2_r2_q <= r2_s.val;
    s2_x_q  <= s1_x_q;
    s2_y_q  <= s1_y_q;

    s3_r4_q <= 64'(s2_r2_q) * 64'(s2_r2_q);
    s3_k1_q <= 64'(coef_i.k1) * 64'(s2_r2_q);
    s3_tx_q <= tx_s.val;
    s3_ty_q <= ty_s.val;
    s3_r2_q <= s2_r2_q;
    s3_xy_q <= s2_xy_q;
    s3_x_q  <= s2_x_q;
    s3_y_q  <= s2_y_q;

    s4_r4_q <= r4_s.val;
    s4_a1_q <= a1_s.val;
    s4_tx_q <= s3_tx_q;
    s4_ty_q <= s3_ty_q;
    s4_r2_q <= s3_r2_q;
    s4_xy_q <= s3_xy_q;
    s4_x_q  <= s3_x_q;
    s4_y_q  <= s3_y_q;

    s5_r6_q <= 64'(s4_r4_q) * 64'(s4_r2_q);
    s5_k2_q <= 64'(coef_i.k2) * 64'(s4_r4_q);
    s5_a1_q <= s4_a1_q;
    s5_tx_q <= s4_tx_q;
    s5_ty_q <= s4_ty_q;
    s5_xy_q <= s4_xy_q;
    s5_x_q  <= s4_x_q;
    s5_y_q  <= s4_y_q;

    s6_r6_q <= r6_s.val;
    s6_a1_q <= s5_a1_q;
    s6_a2_q <= a2_s.val;
    s6_tx_q <= s5_tx_q;
    s6_ty_q <= s5_ty_q;
    s6_xy_q <= s5_xy_q;
    s6_x_q  <= s5_x_q;
    s6_y_q  <= s5_y_q;

    s7_k3_q <= 64'(coef_i.k3) * 64'(s6_r6_q);
    s7_a1_q <= s6_a1_q;
    s7_a2_q <= s6_a2_q;
    s7_tx_q <= s6_tx_q;
    s7_ty_q <= s6_ty_q;
    s7_xy_q <= s6_xy_q;
    s7_x_q  <= s6_x_q;
    s7_y_q  <= s6_y_q;

    s8_f_q  <= f_s.val;
    s8_tx_q <= s7_tx_q;
    s8_ty_q <= s7_ty_q;
    s8_xy_q <= s7_xy_q;
    s8_x_q  <= s7_x_q;
    s8_y_q  <= s7_y_q;

    s9_xf_q   <= 64'(s8_x_q) * 64'(s8_f_q);
    s9_yf_q   <= 64'(s8_y_q) * 64'(s8_f_q);
    s9_p1xy_q <= 64'(coef_i.p1) * 64'(s8_xy_q);
    s9_p2tx_q <= 64'(coef_i.p2) * 64'(s8_tx_q);
    s9_p1ty_q <= 64'(coef_i.p1) * 64'(s8_ty_q);
    s9_p2xy_q <= 64'(coef_i.p2) * 64'(s8_xy_q);

    s10_ox_q <= ox_s.val;
    s10_oy_q <= oy_s.val;
  end

  // Drop the arithmetic for a point at zero or negative depth.
  assign vld_o  = vld_q[NSTG-1];
  assign bad_o  = bad_q[NSTG-1];
  assign ox_o   = bad_q[NSTG-1] ? '0 : s10_ox_q;
  assign oy_o   = bad_q[NSTG-1] ? '0 : s10_oy_q;
  assign clip_o = bad_q[NSTG-1] ? 1'b0 : clip_q[NSTG-1];

endmodule

`default_nettype wire

>>> src/radtan_point_distort.sv
// ----------------------------------------------------------------------------
// radtan_point_distort
// Brown-Conrady radial-tangential distortion of camera-frame points, Q8.24.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ----------------------
//   command   point_x_i point_y_i point_z_i           start_i & !busy_o
//   result    distorted_x_o distorted_y_o             done_o, one cycle
//             bad_depth_o saturated_o
//   config    cfg_idx_i cfg_data_i                    cfg_we_i
//
// One word enters per cycle; busy_o stays low since nothing stalls.
// The path has an operand register, fourteen divider stages (four
// quotient bits each, both coordinates in parallel) and eleven arithmetic
// stages (quotient clip, then alternating 32x32 multiply and round/sum ranks).
// Reset clears the coefficients and all valid bits; results come out in
// order on done_o and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module radtan_point_distort
  import rtp_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [QW-1:0]        point_x_i,
  input  logic signed [QW-1:0]        point_y_i,
  input  logic signed [QW-1:0]        point_z_i,
  output logic                        done_o,
  output logic signed [QW-1:0]        distorted_x_o,
  output logic signed [QW-1:0]        distorted_y_o,
  output logic                        bad_depth_o,
  output logic                        saturated_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [QW-1:0]               cfg_data_i
);

  coef_t     coef_q;
  logic      div_vld;
  div_word_t div_word;
  logic      accept;

  // The pipeline never stalls, so every start is taken.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Coefficient registers; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_K1:  coef_q.k1 <= cfg_data_i;
        REG_K2:  coef_q.k2 <= cfg_data_i;
        REG_K3:  coef_q.k3 <= cfg_data_i;
        REG_P1:  coef_q.p1 <= cfg_data_i;
        REG_P2:  coef_q.p2 <= cfg_data_i;
        default: coef_q    <= coef_q;
      endcase
    end
  end

  // Project onto the z = 1 plane.
  rtp_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (accept),
    .px_i   (point_x_i),
    .py_i   (point_y_i),
    .pz_i   (point_z_i),
    .vld_o  (div_vld),
    .word_o (div_word)
  );

  // Radial factor, tangential terms and final clipping.
  rtp_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_q),
    .vld_i  (div_vld),
    .word_i (div_word),
    .vld_o  (done_o),
    .ox_o   (distorted_x_o),
    .oy_o   (distorted_y_o),
    .bad_o  (bad_depth_o),
    .clip_o (saturated_o)
  );

endmodule

`default_nettype wire

>>> sim/tb_radtan_point_distort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radtan_point_distort
// Self-checking bench for the radial-tangential point distortion block. Points
// go in on the command port with random gaps. Every accepted word is run
// through a fixed-point predictor that keeps its own copy of the coefficients.
// Each result word on done_o is compared field by field with the oldest
// prediction. The run steps through several coefficient sets, the extremes
// among them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_radtan_point_distort;
  import rtp_pkg::*;

  localparam int          NUM_COEF   = 5;
  localparam logic [2:0]  IDX_SPARE0 = 3'd5;
  localparam logic [2:0]  IDX_SPARE6 = 3'd6;
  localparam logic [2:0]  IDX_SPARE7 = 3'd7;
  localparam int          DRAIN_WAIT = 40;
  localparam int          RAND_ITEMS = 310;   // per coefficient set
  localparam longint      Q8_MAX     = 64'sd2147483647;
  localparam longint      Q8_MIN     = -64'sd2147483648;

  typedef struct {
    logic signed [QW-1:0] dist_x;
    logic signed [QW-1:0] dist_y;
    logic                 bad_depth;
    logic                 clipped;
  } distorted_pt_t;

  // Distortion predictor plus the list of points still in flight.
  class distort_scoreboard;
    longint        coef[NUM_COEF];
    bit            clip;
    distorted_pt_t pending[$];
    int            errors;
    int            points;
    int            rejects;
    int            clipped_pts;

    function new();
      foreach (coef[i]) coef[i] = 0;
      errors = 0;
      points = 0;
      rejects = 0;
      clipped_pts = 0;
    endfunction

    // Drop writes to indexes beyond the coefficient file, as the block does.
    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [QW-1:0] data);
      if (idx < NUM_COEF) coef[idx] = longint'($signed(data));
    endfunction

    function longint clamp(longint v);
      if (v > Q8_MAX) begin
        clip = 1'b1;
        return Q8_MAX;
      end
      if (v < Q8_MIN) begin
        clip = 1'b1;
        return Q8_MIN;
      end
      return v;
    endfunction

    // Q8.24 product, rounded to nearest with ties up, then clamped.
    function longint qprod(longint a, longint b);
      longint t;
      t = a * b + 64'sd8388608;
      return clamp(t >>> QFRAC);
    endfunction

    function void note_point(logic signed [QW-1:0] px, logic signed [QW-1:0] py,
                             logic signed [QW-1:0] pz);
      distorted_pt_t e;
      longint x, y, x2, y2, xy, r2, r4, r6, f, tx, ty, ox, oy;
      points++;
      clip = 1'b0;
      if (pz <= 0) begin
        e = '{dist_x: '0, dist_y: '0, bad_depth: 1'b1, clipped: 1'b0};
        rejects++;
        pending.push_back(e);
        return;
      end
      x  = clamp((longint'(px) * 64'sd16777216) / longint'(pz));
      y  = clamp((longint'(py) * 64'sd16777216) / longint'(pz));
      x2 = qprod(x, x);
      y2 = qprod(y, y);
      xy = qprod(x, y);
      r2 = clamp(x2 + y2);
      r4 = qprod(r2, r2);
      r6 = qprod(r4, r2);
      f  = clamp(64'sd16777216 + qprod(coef[REG_K1], r2) + qprod(coef[REG_K2], r4)
                 + qprod(coef[REG_K3], r6));
      tx = clamp(r2 + 2 * x2);
      ty = clamp(r2 + 2 * y2);
      ox = clamp(qprod(x, f) + 2 * qprod(coef[REG_P1], xy) + qprod(coef[REG_P2], tx));
      oy = clamp(qprod(y, f) + qprod(coef[REG_P1], ty) + 2 * qprod(coef[REG_P2], xy));
      e.dist_x    = ox[QW-1:0];
      e.dist_y    = oy[QW-1:0];
      e.bad_depth = 1'b0;
      e.clipped   = clip;
      if (clip) clipped_pts++;
      pending.push_back(e);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(distorted_pt_t got);
      distorted_pt_t e;
      if (pending.size() == 0) begin
        report("result word with no point pending");
        return;
      end
      e = pending.pop_front();
      if (got.dist_x !== e.dist_x)
        report($sformatf("distorted_x %h, want %h", got.dist_x, e.dist_x));
      if (got.dist_y !== e.dist_y)
        report($sformatf("distorted_y %h, want %h", got.dist_y, e.dist_y));
      if (got.bad_depth !== e.bad_depth)
        report($sformatf("bad_depth %b, want %b", got.bad_depth, e.bad_depth));
      if (got.clipped !== e.clipped)
        report($sformatf("saturated %b, want %b", got.clipped, e.clipped));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic signed [QW-1:0] point_x_i;
  logic signed [QW-1:0] point_y_i;
  logic signed [QW-1:0] point_z_i;
  logic                 done_o;
  logic signed [QW-1:0] distorted_x_o;
  logic signed [QW-1:0] distorted_y_o;
  logic                 bad_depth_o;
  logic                 saturated_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [QW-1:0]        cfg_data_i;

  distort_scoreboard sb;
  int                coef_sets;
  bit                no_gaps;

  radtan_point_distort DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .done_o        (done_o),
    .distorted_x_o (distorted_x_o),
    .distorted_y_o (distorted_y_o),
    .bad_depth_o   (bad_depth_o),
    .saturated_o   (saturated_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Sample result words at the edge that ends their cycle; values read here
  // are the ones from before the edge.
  always @(posedge clk_i) begin
    distorted_pt_t got;
    if (rst_ni && done_o) begin
      got = '{dist_x: distorted_x_o, dist_y: distorted_y_o,
              bad_depth: bad_depth_o, clipped: saturated_o};
      sb.check_result(got);
    end
  end

  // Generous ceiling: ~2000 words with long gaps stay well under 1 ms.
  initial begin
    #50ms;
    $display("timeout with %0d words still pending", sb.pending.size());
    $display("** radtan_point_distort: FAILED **");
    $finish;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Signed random value of the given magnitude in bits.
  function automatic logic [QW-1:0] srand_bits(int bits);
    logic signed [QW-1:0] v;
    v = $signed($urandom);
    return v >>> (QW - bits);
  endfunction

  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [QW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_coef(idx, data);
  endtask

  task automatic load_coefs(logic [QW-1:0] k1, logic [QW-1:0] k2, logic [QW-1:0] k3,
                            logic [QW-1:0] p1, logic [QW-1:0] p2);
    write_coef(REG_K1, k1);
    write_coef(REG_K2, k2);
    write_coef(REG_K3, k3);
    write_coef(REG_P1, p1);
    write_coef(REG_P2, p2);
    coef_sets++;
  endtask

  // Hold the word until the block takes it, then idle for a random gap.
  task automatic send_point(logic [QW-1:0] px, logic [QW-1:0] py, logic [QW-1:0] pz);
    int gap;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    start_i   <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.note_point(px, py, pz);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly points in front of the lens at sane distances, some raw noise,
  // some at or behind the image plane.
  task automatic send_random_point();
    int          roll;
    logic [QW-1:0] z;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      send_point($urandom, $urandom, $urandom);
    end else if (roll == 1) begin
      z = ($urandom_range(0, 2) == 0) ? '0 : srand_bits($urandom_range(2, 32));
      send_point($urandom, $urandom, {1'b1, z[QW-2:0]});
    end else begin
      z = $urandom_range(32'h0040_0000, 32'h0800_0000);
      send_point(srand_bits($urandom_range(20, 28)), srand_bits($urandom_range(20, 28)), z);
    end
  endtask

  task automatic run_random(int n);
    no_gaps = 1'b0;
    for (int i = 0; i < n; i++) begin
      // Every so often, run a gapless burst.
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_random_point();
    end
  endtask

  // Let every pending word come out before touching the coefficients.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  initial begin
    sb         = new();
    coef_sets  = 1;
    no_gaps    = 1'b0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    point_x_i  = '0;
    point_y_i  = '0;
    point_z_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients: pure pinhole projection.
    send_point(32'h0100_0000, 32'hff00_0000, 32'h0100_0000);
    run_random(RAND_ITEMS);
    drain();

    // Typical lens; junk written to spare indexes must not land anywhere.
    write_coef(IDX_SPARE0, 32'hdead_beef);
    write_coef(IDX_SPARE7, 32'h7fff_ffff);
    load_coefs(32'hfff0_0000 - 32'h0040_0000, 32'h0010_0000, 32'hffff_8000,
               32'h0000_4000, 32'hffff_c000);
    write_coef(IDX_SPARE6, 32'h8000_0000);

    // Directed: field extremes, depth zero and negative, tiny and huge depth.
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_point(32'h0100_0000, 32'h0100_0000, 32'h0000_0000);
    send_point(32'h0100_0000, 32'h0100_0000, 32'hffff_ffff);
    send_point(32'h0100_0000, 32'h0100_0000, 32'h8000_0000);
    send_point(32'h0000_0001, 32'hffff_ffff, 32'h0100_0000);
    send_point(32'h0080_0000, 32'hff80_0000, 32'h0100_0000);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h0000_0002);
    send_point(32'h0200_0000, 32'h0300_0000, 32'h0100_0000);
    send_point(32'h0000_0000, 32'h7fff_ffff, 32'h0100_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(32'h1234_5678, 32'hedcb_a988, 32'h0800_0000);
    run_random(RAND_ITEMS);
    drain();

    // Fully random coefficients.
    load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(RAND_ITEMS);
    drain();

    // Positive extreme on every coefficient.
    load_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
    run_random(RAND_ITEMS);
    drain();

    // Negative extreme on every coefficient.
    load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hff00_0000, 32'h0100_0000, 32'h0100_0000);
    run_random(RAND_ITEMS);
    drain();

    // Small random lens.
    load_coefs(srand_bits(25), srand_bits(24), srand_bits(23), srand_bits(18), srand_bits(18));
    run_random(RAND_ITEMS);
    drain();

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    $display("run covered %0d points over %0d coefficient sets", sb.points, coef_sets);
    $display("of those, %0d had bad depth and %0d clipped", sb.rejects, sb.clipped_pts);
    if (sb.errors == 0) begin
      $display("** radtan_point_distort: PASSED **");
    end else begin
      $display("** radtan_point_distort: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
